### design/msns_pkg.sv
// shared types and constants for the music string note sequencer
// used by the top level, the divider and the port checker; no dependencies
package msns_pkg;

  localparam logic [17:0] DurMax       = 18'h3FFFF;
  localparam logic [17:0] WholeDefault = 18'd2000;
  localparam logic [17:0] DurDefault   = 18'd500;
  localparam logic [17:0] TempoNum     = 18'd24000;
  localparam logic [15:0] AccMax       = 16'hFFFF;
  localparam logic [15:0] VolDefault   = 16'd15;
  localparam logic [15:0] DivDefault   = 16'd4;
  localparam logic [7:0]  OctDefault   = 8'd4;
  localparam logic [4:0]  DivSteps     = 5'd18;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLess  = 8'h3C;
  localparam logic [7:0] ChMore  = 8'h3E;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChC     = 8'h63;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChO     = 8'h6F;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChV     = 8'h76;

  typedef enum logic [1:0] {
    KIND_TONE    = 2'd0,
    KIND_SILENCE = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  note;
    logic [17:0] dur;
    logic [3:0]  vol;
    logic        ends;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [17:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [17:0] quotient;
  } div_rsp_t;

endpackage

### design/msns_div.sv
// iterative restoring divider, one quotient bit per cycle
// uses msns_pkg; a zero divisor gives an all-ones quotient
module msns_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msns_pkg::div_req_t req_i,
  output msns_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [17:0] dvd_q, dvd_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] rem_ext;
  logic [17:0] diff;

  assign rem_ext = {rem_q, dvd_q[17]};
  assign diff    = {1'b0, rem_ext} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (diff[17]) begin
        rem_d = rem_ext[15:0];
        dvd_d = {dvd_q[16:0], 1'b0};
      end else begin
        rem_d = diff[15:0];
        dvd_d = {dvd_q[16:0], 1'b1};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == msns_pkg::DivSteps - 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

### design/music_string_note_sequencer_unit.sv
// top level of the music string note sequencer
// uses msns_pkg and msns_div
//
// takes one character beat at a time and turns music-string commands into
// tone, silence and end beats. the block is busy while a character is
// worked on, and every division runs through one shared 18-step restoring
// divider (an l command or a note with a length needs one division, a t
// command two, or one for a zero tempo). each result beat then waits on
// the output until it is taken, and the input stays stalled until the last
// result beat of the character is taken. after a nul or an unknown character
// the string is ended and further characters are swallowed without result
// until sequence_start is set.
module music_string_note_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        sequence_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  note_number_o,
  output logic [17:0] duration_ms_o,
  output logic [3:0]  note_volume_o,
  output logic        sequence_ends_o,
  output logic        last_of_run_o
);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRE  = 6'b000010,
    S_DIV  = 6'b000100,
    S_TAIL = 6'b001000,
    S_CMD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  // parser modes
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_NUM_O = 4'd1,
    M_NUM_L = 4'd2,
    M_NUM_T = 4'd3,
    M_NUM_V = 4'd4,
    M_MWAIT = 4'd5,
    M_SHARP = 4'd6,
    M_FLAT  = 4'd7,
    M_LEN   = 4'd8,
    M_DOTS  = 4'd9,
    M_DONE  = 4'd10
  } mode_e;

  // what the running division is for
  typedef enum logic [1:0] {
    P_LDEF   = 2'd0,
    P_TWHOLE = 2'd1,
    P_TDEF   = 2'd2,
    P_LEN    = 2'd3
  } purp_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  purp_e  purp_q, purp_d;

  logic [7:0]  ch_q, ch_d;
  logic [7:0]  base_q, base_d;
  logic [7:0]  temp_q, temp_d;
  logic [17:0] whole_q, whole_d;
  logic [15:0] ndiv_q, ndiv_d;
  logic [17:0] dflt_q, dflt_d;
  logic [15:0] vol_q, vol_d;
  logic        stacc_q, stacc_d;
  logic [7:0]  pnote_q, pnote_d;
  logic        prest_q, prest_d;
  logic [17:0] pdur_q, pdur_d;
  logic [17:0] dot_q, dot_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        idx_q, idx_d;

  msns_pkg::res_t     buf_q [2];
  msns_pkg::res_t     buf_d [2];
  msns_pkg::div_req_t div_req;
  msns_pkg::div_rsp_t div_rsp;

  logic        in_acc;
  logic [7:0]  ch_fold;
  logic        is_digit;
  logic [19:0] acc_next;
  logic [15:0] acc_sat;
  logic [17:0] q_x10;
  logic [18:0] dot_sum;
  logic [17:0] half_dur;
  logic [3:0]  vol_clip;
  logic [3:0]  note_off;
  logic [7:0]  oct_semis;

  msns_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // case folding of upper-case letters
  always_comb begin
    ch_fold = character_i;
    if (character_i inside {[msns_pkg::ChUpA:msns_pkg::ChUpZ]}) begin
      ch_fold = character_i + 8'd32;
    end
  end

  assign is_digit  = ch_q inside {[msns_pkg::ChZero:msns_pkg::ChNine]};
  // saturating decimal accumulate
  assign acc_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                     + {12'd0, ch_q - msns_pkg::ChZero};
  assign acc_sat   = (|acc_next[19:16]) ? msns_pkg::AccMax : acc_next[15:0];
  assign q_x10     = {div_rsp.quotient[14:0], 3'b000} + {div_rsp.quotient[16:0], 1'b0};
  assign dot_sum   = {1'b0, pdur_q} + {1'b0, dot_q};
  assign half_dur  = stacc_q ? {1'b0, pdur_q[17:1]} : 18'd0;
  assign vol_clip  = (|vol_q[15:4]) ? 4'd15 : vol_q[3:0];
  assign oct_semis = {temp_q[4:0], 3'b000} + {temp_q[5:0], 2'b00};

  // semitone offset of a note letter within the octave
  always_comb begin
    case (ch_q)
      msns_pkg::ChD: note_off = 4'd2;
      msns_pkg::ChE: note_off = 4'd4;
      msns_pkg::ChF: note_off = 4'd5;
      msns_pkg::ChG: note_off = 4'd7;
      msns_pkg::ChA: note_off = 4'd9;
      msns_pkg::ChB: note_off = 4'd11;
      default:       note_off = 4'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    purp_d  = purp_q;
    ch_d    = ch_q;
    base_d  = base_q;
    temp_d  = temp_q;
    whole_d = whole_q;
    ndiv_d  = ndiv_q;
    dflt_d  = dflt_q;
    vol_d   = vol_q;
    stacc_d = stacc_q;
    pnote_d = pnote_q;
    prest_d = prest_q;
    pdur_d  = pdur_q;
    dot_d   = dot_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    buf_d   = buf_q;
    div_req = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ch_d    = ch_fold;
          cnt_d   = 2'd0;
          state_d = S_PRE;
          // a new string drops any partial parse
          if (sequence_start_i) begin
            mode_d  = M_IDLE;
            temp_d  = base_q;
            pnote_d = '0;
            prest_d = 1'b0;
            pdur_d  = '0;
            dot_d   = '0;
            acc_d   = '0;
          end
        end
      end

      S_PRE: begin
        if (ch_q == msns_pkg::ChSpace || mode_q == M_DONE) begin
          state_d = S_IDLE;
        end else begin
          case (mode_q)
            M_NUM_O, M_NUM_L, M_NUM_T, M_NUM_V: begin
              if (is_digit) begin
                acc_d   = acc_sat;
                state_d = S_IDLE;
              end else begin
                mode_d  = M_IDLE;
                state_d = S_CMD;
                case (mode_q)
                  M_NUM_O: begin
                    base_d = acc_q[7:0];
                    temp_d = acc_q[7:0];
                  end
                  M_NUM_L: begin
                    ndiv_d           = acc_q;
                    div_req.start    = 1'b1;
                    div_req.dividend = whole_q;
                    div_req.divisor  = acc_q;
                    purp_d           = P_LDEF;
                    state_d          = S_DIV;
                  end
                  M_NUM_T: begin
                    div_req.start = 1'b1;
                    state_d       = S_DIV;
                    if (acc_q == 16'd0) begin
                      whole_d          = msns_pkg::DurMax;
                      div_req.dividend = msns_pkg::DurMax;
                      div_req.divisor  = ndiv_q;
                      purp_d           = P_TDEF;
                    end else begin
                      div_req.dividend = msns_pkg::TempoNum;
                      div_req.divisor  = acc_q;
                      purp_d           = P_TWHOLE;
                    end
                  end
                  default: vol_d = acc_q;
                endcase
              end
            end
            M_MWAIT: begin
              stacc_d = (ch_q != msns_pkg::ChL);
              mode_d  = M_IDLE;
              // a nul after m still ends the string
              state_d = (ch_q == msns_pkg::ChNul) ? S_CMD : S_IDLE;
            end
            M_SHARP, M_FLAT: begin
              if (mode_q == M_SHARP &&
                  (ch_q == msns_pkg::ChPlus || ch_q == msns_pkg::ChHash)) begin
                pnote_d = pnote_q + 8'd1;
                state_d = S_IDLE;
              end else if (ch_q == msns_pkg::ChMinus) begin
                pnote_d = pnote_q - 8'd1;
                mode_d  = M_FLAT;
                state_d = S_IDLE;
              end else if (ch_q inside {[msns_pkg::ChOne:msns_pkg::ChEight]}) begin
                acc_d   = {8'd0, ch_q - msns_pkg::ChZero};
                mode_d  = M_LEN;
                state_d = S_IDLE;
              end else begin
                state_d = S_TAIL;
              end
            end
            M_LEN: begin
              if (is_digit) begin
                acc_d   = acc_sat;
                state_d = S_IDLE;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = whole_q;
                div_req.divisor  = acc_q;
                purp_d           = P_LEN;
                state_d          = S_DIV;
              end
            end
            M_DOTS:  state_d = S_TAIL;
            default: state_d = S_CMD;
          endcase
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          case (purp_q)
            P_LDEF, P_TDEF: begin
              dflt_d  = div_rsp.quotient;
              state_d = S_CMD;
            end
            P_TWHOLE: begin
              // tempo result still needs the default length
              whole_d          = q_x10;
              div_req.start    = 1'b1;
              div_req.dividend = q_x10;
              div_req.divisor  = ndiv_q;
              purp_d           = P_TDEF;
            end
            default: begin
              pdur_d  = div_rsp.quotient;
              dot_d   = {1'b0, div_rsp.quotient[17:1]};
              mode_d  = M_DOTS;
              state_d = S_TAIL;
            end
          endcase
        end
      end

      S_TAIL: begin
        if (ch_q == msns_pkg::ChDot) begin
          pdur_d  = dot_sum[18] ? msns_pkg::DurMax : dot_sum[17:0];
          dot_d   = {1'b0, dot_q[17:1]};
          mode_d  = M_DOTS;
          state_d = S_IDLE;
        end else begin
          // finish the pending note, staccato splits off a silence
          buf_d[0].dur  = pdur_q - half_dur;
          buf_d[0].ends = 1'b0;
          buf_d[0].last = 1'b0;
          if (prest_q) begin
            buf_d[0].kind = msns_pkg::KIND_SILENCE;
            buf_d[0].note = '0;
            buf_d[0].vol  = '0;
          end else begin
            buf_d[0].kind = msns_pkg::KIND_TONE;
            buf_d[0].note = pnote_q;
            buf_d[0].vol  = vol_clip;
          end
          buf_d[1].kind = msns_pkg::KIND_SILENCE;
          buf_d[1].note = '0;
          buf_d[1].dur  = half_dur;
          buf_d[1].vol  = '0;
          buf_d[1].ends = 1'b0;
          buf_d[1].last = 1'b0;
          cnt_d   = (half_dur != 18'd0) ? 2'd2 : 2'd1;
          temp_d  = base_q;
          mode_d  = M_IDLE;
          state_d = S_CMD;
        end
      end

      S_CMD: begin
        case (ch_q)
          msns_pkg::ChMore: temp_d = temp_q + 8'd1;
          msns_pkg::ChLess: temp_d = temp_q - 8'd1;
          msns_pkg::ChA, msns_pkg::ChB, msns_pkg::ChC, msns_pkg::ChD,
          msns_pkg::ChE, msns_pkg::ChF, msns_pkg::ChG, msns_pkg::ChR: begin
            prest_d = (ch_q == msns_pkg::ChR);
            pnote_d = oct_semis + {4'd0, note_off};
            pdur_d  = dflt_q;
            dot_d   = {1'b0, dflt_q[17:1]};
            mode_d  = M_SHARP;
          end
          msns_pkg::ChO: begin
            acc_d  = '0;
            mode_d = M_NUM_O;
          end
          msns_pkg::ChL: begin
            acc_d  = '0;
            mode_d = M_NUM_L;
          end
          msns_pkg::ChT: begin
            acc_d  = '0;
            mode_d = M_NUM_T;
          end
          msns_pkg::ChV: begin
            acc_d  = '0;
            mode_d = M_NUM_V;
          end
          msns_pkg::ChM: mode_d = M_MWAIT;
          msns_pkg::ChBang: begin
            base_d  = msns_pkg::OctDefault;
            temp_d  = msns_pkg::OctDefault;
            whole_d = msns_pkg::WholeDefault;
            ndiv_d  = msns_pkg::DivDefault;
            dflt_d  = msns_pkg::DurDefault;
            vol_d   = msns_pkg::VolDefault;
            stacc_d = 1'b0;
          end
          default: begin
            // end of string: flag the last beat, or send a bare end beat
            mode_d = M_DONE;
            if (cnt_q == 2'd0) begin
              buf_d[0].kind = msns_pkg::KIND_END;
              buf_d[0].note = '0;
              buf_d[0].dur  = '0;
              buf_d[0].vol  = '0;
              buf_d[0].ends = 1'b1;
              buf_d[0].last = 1'b0;
              cnt_d         = 2'd1;
            end else if (cnt_q == 2'd2) begin
              buf_d[1].ends = 1'b1;
            end else begin
              buf_d[0].ends = 1'b1;
            end
          end
        endcase
        if (cnt_d == 2'd0) begin
          state_d = S_IDLE;
        end else begin
          if (cnt_d == 2'd2) begin
            buf_d[1].last = 1'b1;
          end else begin
            buf_d[0].last = 1'b1;
          end
          idx_d   = 1'b0;
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_stall_i) begin
          if ({1'b0, idx_q} == cnt_q - 2'd1) begin
            state_d = S_IDLE;
          end else begin
            idx_d = 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_IDLE;
      purp_q  <= P_LDEF;
      base_q  <= msns_pkg::OctDefault;
      temp_q  <= msns_pkg::OctDefault;
      whole_q <= msns_pkg::WholeDefault;
      ndiv_q  <= msns_pkg::DivDefault;
      dflt_q  <= msns_pkg::DurDefault;
      vol_q   <= msns_pkg::VolDefault;
      stacc_q <= 1'b0;
      pnote_q <= '0;
      prest_q <= 1'b0;
      pdur_q  <= '0;
      dot_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      purp_q  <= purp_d;
      base_q  <= base_d;
      temp_q  <= temp_d;
      whole_q <= whole_d;
      ndiv_q  <= ndiv_d;
      dflt_q  <= dflt_d;
      vol_q   <= vol_d;
      stacc_q <= stacc_d;
      pnote_q <= pnote_d;
      prest_q <= prest_d;
      pdur_q  <= pdur_d;
      dot_q   <= dot_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    buf_q  <= buf_d;
  end

  // result beat on the output
  assign out_valid_o     = (state_q == S_OUT);
  assign item_kind_o     = buf_q[idx_q].kind;
  assign note_number_o   = buf_q[idx_q].note;
  assign duration_ms_o   = buf_q[idx_q].dur;
  assign note_volume_o   = buf_q[idx_q].vol;
  assign sequence_ends_o = buf_q[idx_q].ends;
  assign last_of_run_o   = buf_q[idx_q].last;

endmodule

### design/msns_port_check.sv
// port-level checks for the music string note sequencer
// uses msns_pkg; bound to music_string_note_sequencer_unit
module msns_port_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  item_kind_o,
  input logic [7:0]  note_number_o,
  input logic [17:0] duration_ms_o,
  input logic [3:0]  note_volume_o,
  input logic        sequence_ends_o,
  input logic        last_of_run_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duration_ms_o)
      && $stable(item_kind_o) && $stable(note_number_o))
    else $error("stalled result beat changed");

  // no character is taken while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready while results pending");

  // the beat that ends the string is the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sequence_ends_o |-> last_of_run_o)
    else $error("end beat not last of run");

  // end beats carry no sound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == msns_pkg::KIND_END |->
      sequence_ends_o && duration_ms_o == 18'd0 && note_volume_o == 4'd0)
    else $error("malformed end beat");

  // an accepted character causes no result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind music_string_note_sequencer_unit msns_port_check u_msns_port_check (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .item_kind_o     (item_kind_o),
  .note_number_o   (note_number_o),
  .duration_ms_o   (duration_ms_o),
  .note_volume_o   (note_volume_o),
  .sequence_ends_o (sequence_ends_o),
  .last_of_run_o   (last_of_run_o)
);
